### design/e2g_pkg.sv
// Constants, types and the CORDIC angle table for the ECEF to geodetic converter.
`default_nettype none

package e2g_pkg;

  localparam int unsigned CSTEPS = 62;

  typedef logic [CSTEPS-1:0][63:0] atab_t;

  // Semi-major axis in millimetres, shared by both ellipsoids
  localparam logic [32:0] A_MM = 33'd6378137000;
  // First eccentricity squared, Q56
  localparam logic [48:0] E2_WGS84 = 49'd482380916678511;
  localparam logic [48:0] E2_CGCS = 49'd482380918930455;
  // CORDIC start gain, Q62
  localparam logic signed [63:0] KINV_Q62 = 64'sd2800459870029430000;
  localparam logic [63:0] INVPI_Q64 = 64'h517CC1B727220A95;
  // Half turn in internal angle units
  localparam logic signed [63:0] HALF_TURN = 64'sd2305843009213693952;
  // One degree in internal angle units, rounded to nearest
  localparam logic signed [63:0] ONE_DEG = 64'sd12810238940076078;
  // Sine limit, Q62
  localparam logic signed [63:0] SIN_LIM = 64'sd4611686018427387904;
  // Saturation point of Z / sin B, Q8 mm
  localparam logic [50:0] ZS_CAP = 51'd1125899906842624;
  localparam logic signed [45:0] H_MAX = 46'sd34359738367;
  localparam logic signed [45:0] H_MIN = -46'sd34359738368;

  // atan(2^-i) / pi in Q61 half turns, from the arctangent series
  function automatic atab_t build_atab();
    atab_t t;
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] term;
    logic [63:0] rem;
    logic [63:0] den;
    logic [127:0] p;
    int i;
    int k;
    int b;
    t = '0;
    t[0] = 64'd1 << 59;
    for (i = 1; i < CSTEPS; i++) begin
      sum = '0;
      for (k = 0; i * (2 * k + 1) <= 62; k++) begin
        num = 64'd1 << (62 - i * (2 * k + 1));
        den = 64'(2 * k + 1);
        rem = '0;
        term = '0;
        for (b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= den) begin
            rem = rem - den;
            term[b] = 1'b1;
          end
        end
        if ((k & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      p = {64'd0, sum} * {64'd0, INVPI_Q64};
      t[i] = {1'b0, p[127:65]};
    end
    return t;
  endfunction

endpackage

`default_nettype wire

### design/ecef_to_geodetic_iterative.sv
// ECEF to geodetic converter: sequencer around shared CORDIC, multiplier and shift-subtract units.
//
//  channel | direction | handshake                  | beat
//  in      | in        | in_valid_i / in_ready_o    | x_mm_i, y_mm_i, z_mm_i
//  out     | out       | out_valid_o / out_ready_i  | latitude_o .. height_invalid_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_ellipsoid_select_i
//
// An item takes a setup phase and then at most MAX_ITERATIONS latitude passes. Each pass
// is set by up to two 128-step divisions, a 64-step root and two 62-step CORDIC runs.
// in_ready_o is high only while the sequencer is idle. A finished result sits in the
// output register; the next item is taken meanwhile and waits at its end if still full.
// Reset is asynchronous and clears the sequencer, the output valid and the ellipsoid select.
`default_nettype none

module ecef_to_geodetic_iterative #(
  parameter int MAX_ITERATIONS = 100,
  parameter int ANGLE_BITS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire                cfg_ellipsoid_select_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire signed [35:0]  x_mm_i,
  input  wire signed [35:0]  y_mm_i,
  input  wire signed [35:0]  z_mm_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic signed [31:0] latitude_o,
  output logic signed [31:0] longitude_o,
  output logic signed [35:0] height_mm_o,
  output logic               converged_o,
  output logic               height_invalid_o
);

  localparam int QW = ANGLE_BITS + 1;
  localparam int QSHIFT = 62 - ANGLE_BITS;
  localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
  localparam logic signed [63:0] B0_RSUM = e2g_pkg::ONE_DEG + (64'sd1 <<< (QSHIFT - 1));
  localparam logic signed [QW-1:0] B0Q = B0_RSUM[QSHIFT +: QW];
  localparam e2g_pkg::atab_t ATAB = e2g_pkg::build_atab();

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_NORM   = 5'd1;
  localparam logic [4:0] S_CORD   = 5'd2;
  localparam logic [4:0] S_MUL    = 5'd3;
  localparam logic [4:0] S_SQRT   = 5'd4;
  localparam logic [4:0] S_DIV    = 5'd5;
  localparam logic [4:0] S_G_LON  = 5'd6;
  localparam logic [4:0] S_G_XX   = 5'd7;
  localparam logic [4:0] S_G_YY   = 5'd8;
  localparam logic [4:0] S_G_DOWN = 5'd9;
  localparam logic [4:0] S_IT     = 5'd10;
  localparam logic [4:0] S_G_SIN  = 5'd11;
  localparam logic [4:0] S_G_S2   = 5'd12;
  localparam logic [4:0] S_G_W2   = 5'd13;
  localparam logic [4:0] S_G_W    = 5'd14;
  localparam logic [4:0] S_G_N    = 5'd15;
  localparam logic [4:0] S_G_U    = 5'd16;
  localparam logic [4:0] S_G_NE   = 5'd17;
  localparam logic [4:0] S_G_LAT  = 5'd18;
  localparam logic [4:0] S_G_Q    = 5'd19;
  localparam logic [4:0] S_G_H    = 5'd20;
  localparam logic [4:0] S_G_CHK  = 5'd21;
  localparam logic [4:0] S_DONE   = 5'd22;

  // control state
  logic [4:0] state_q, state_d, ret_q, ret_d;
  logic [6:0] cnt_q, cnt_d;
  logic [IT_W-1:0] it_q, it_d;
  logic ell_q, ell_d;
  logic out_valid_q, out_valid_d;

  // datapath
  logic cmode_q, cmode_d, negy_q, negy_d;
  logic signed [63:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [63:0] ma_q, ma_d, mb_q, mb_d, rem_q, rem_d, res_q, res_d;
  logic [127:0] acc_q, acc_d;
  logic signed [35:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [QW-1:0] lonq_q, lonq_d, latq_q, latq_d, b0q_q, b0q_d;
  logic [43:0] down_q, down_d;
  logic signed [63:0] s_q, s_d;
  logic [47:0] nq8_q, nq8_d;
  logic signed [51:0] zs_q, zs_d;
  logic signed [35:0] height_q, height_d;
  logic conv_q, conv_d, inval_q, inval_d;
  logic [31:0] lat_o_q, lat_o_d, lon_o_q, lon_o_d;
  logic [35:0] hgt_o_q, hgt_o_d;
  logic conv_o_q, conv_o_d, inval_o_q, inval_o_d;

  // shared helpers
  logic [48:0] e2_w;
  logic [55:0] ome2_w;
  logic [63:0] as_w;
  logic [35:0] ax_w, ay_w, az_w;
  logic signed [63:0] at_y, at_x, at_z, up_w, z256_w, ne2s_w;
  logic [63:0] at_ax, at_ay;
  logic at_neg, at_zero;
  logic [5:0] idx;
  logic signed [63:0] ang, sx, sy;
  logic cpos;
  logic [15:0] chunk;
  logic [79:0] prod;
  logic [63:0] cs_a, cs_b, cs_diff;
  logic cs_ge;
  logic signed [63:0] sin_cl, rnd_sum;
  logic [63:0] sin_mag, w2_w, qhi_w;
  logic signed [QW-1:0] rnd_q;
  logic [50:0] q_w;
  logic [42:0] m_w;
  logic signed [53:0] hq8_w, rh_sum;
  logic signed [45:0] rh_w;
  logic signed [63:0] lat_f, lon_f, lat_sum, lon_sum;

  assign e2_w = ell_q ? e2g_pkg::E2_CGCS : e2g_pkg::E2_WGS84;
  assign ome2_w = 56'(57'd1 << 56) - 56'(e2_w);
  assign as_w = s_q[63] ? 64'(-s_q) : 64'(s_q);
  assign ax_w = x_q[35] ? 36'(-x_q) : 36'(x_q);
  assign ay_w = y_q[35] ? 36'(-y_q) : 36'(y_q);
  assign az_w = z_q[35] ? 36'(-z_q) : 36'(z_q);

  // latitude numerator: Z in Q8 plus N e2 sin B0
  assign z256_w = 64'(z_q) <<< 8;
  assign ne2s_w = $signed(acc_q[125:62]);
  assign up_w = s_q[63] ? z256_w - ne2s_w : z256_w + ne2s_w;

  // vectoring entry: fold into the right half-plane
  assign at_y = (state_q == S_IDLE) ? 64'(y_mm_i) : up_w;
  assign at_x = (state_q == S_IDLE) ? 64'(x_mm_i) : $signed({20'd0, down_q});
  assign at_ax = at_x[63] ? 64'(-at_x) : 64'(at_x);
  assign at_ay = at_y[63] ? 64'(-at_y) : 64'(at_y);
  assign at_zero = (at_ax == '0) && (at_ay == '0);
  assign at_neg = at_x[63] ? !at_y[63] : at_y[63];
  assign at_z = at_x[63] ? (at_y[63] ? -e2g_pkg::HALF_TURN : e2g_pkg::HALF_TURN) : 64'sd0;

  // one CORDIC micro-rotation
  assign idx = cnt_q[5:0];
  assign ang = $signed(ATAB[idx]);
  assign sx = cx_q >>> idx;
  assign sy = cy_q >>> idx;
  assign cpos = cmode_q ? cy_q[63] : !cz_q[63];

  // 64 x 16 partial product
  assign chunk = mb_q[{cnt_q[1:0], 4'd0} +: 16];
  assign prod = ma_q * chunk;

  // shift-subtract step shared by root and division
  always_comb begin
    if (state_q == S_SQRT) begin
      cs_a = {rem_q[61:0], acc_q[127:126]};
      cs_b = {res_q[61:0], 2'b01};
    end else begin
      cs_a = {rem_q[62:0], acc_q[127]};
      cs_b = ma_q;
    end
  end
  assign cs_ge = cs_a >= cs_b;
  assign cs_diff = cs_a - cs_b;

  assign sin_cl = (cy_q > e2g_pkg::SIN_LIM) ? e2g_pkg::SIN_LIM :
                  (cy_q < -e2g_pkg::SIN_LIM) ? -e2g_pkg::SIN_LIM : cy_q;
  assign sin_mag = sin_cl[63] ? 64'(-sin_cl) : 64'(sin_cl);
  assign w2_w = (64'd1 << 62) - acc_q[119:56];
  assign qhi_w = {22'd0, az_w, 6'd0};

  assign rnd_sum = cz_q + (64'sd1 <<< (QSHIFT - 1));
  assign rnd_q = rnd_sum[QSHIFT +: QW];

  assign q_w = (res_q > 64'(e2g_pkg::ZS_CAP)) ? e2g_pkg::ZS_CAP : res_q[50:0];
  assign m_w = acc_q[98:56];
  assign hq8_w = 54'(zs_q) - $signed({11'd0, m_w});
  assign rh_sum = hq8_w + 54'sd128;
  assign rh_w = rh_sum[53:8];

  assign lat_f = 64'(latq_q) <<< QSHIFT;
  assign lon_f = 64'(lonq_q) <<< QSHIFT;
  assign lat_sum = lat_f + 64'sd536870912;
  assign lon_sum = lon_f + 64'sd536870912;

  always_comb begin
    state_d = state_q;
    ret_d = ret_q;
    cnt_d = cnt_q;
    it_d = it_q;
    ell_d = ell_q;
    out_valid_d = out_valid_q;
    cmode_d = cmode_q;
    negy_d = negy_q;
    cx_d = cx_q;
    cy_d = cy_q;
    cz_d = cz_q;
    ma_d = ma_q;
    mb_d = mb_q;
    rem_d = rem_q;
    res_d = res_q;
    acc_d = acc_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    lonq_d = lonq_q;
    latq_d = latq_q;
    b0q_d = b0q_q;
    down_d = down_q;
    s_d = s_q;
    nq8_d = nq8_q;
    zs_d = zs_q;
    height_d = height_q;
    conv_d = conv_q;
    inval_d = inval_q;
    lat_o_d = lat_o_q;
    lon_o_d = lon_o_q;
    hgt_o_d = hgt_o_q;
    conv_o_d = conv_o_q;
    inval_o_d = inval_o_q;

    if (cfg_valid_i) begin
      ell_d = cfg_ellipsoid_select_i;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          x_d = x_mm_i;
          y_d = y_mm_i;
          z_d = z_mm_i;
          ret_d = S_G_LON;
          if (at_zero) begin
            cz_d = '0;
            state_d = S_G_LON;
          end else begin
            cx_d = $signed(at_ax);
            cy_d = $signed(at_ay);
            cz_d = at_z;
            negy_d = at_neg;
            cmode_d = 1'b1;
            state_d = S_NORM;
          end
        end
      end
      S_NORM: begin
        if (cx_q[63:59] == '0 && cy_q[63:59] == '0) begin
          cx_d = cx_q <<< 1;
          cy_d = cy_q <<< 1;
        end else begin
          cy_d = negy_q ? -cy_q : cy_q;
          cnt_d = '0;
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        if (cpos) begin
          cx_d = cx_q - sy;
          cy_d = cy_q + sx;
          cz_d = cz_q - ang;
        end else begin
          cx_d = cx_q + sy;
          cy_d = cy_q - sx;
          cz_d = cz_q + ang;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(e2g_pkg::CSTEPS - 1)) begin
          state_d = ret_q;
        end
      end
      S_MUL: begin
        acc_d = acc_q + ({48'd0, prod} << {cnt_q[1:0], 4'd0});
        cnt_d = cnt_q + 7'd1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = ret_q;
        end
      end
      S_SQRT, S_DIV: begin
        rem_d = cs_ge ? cs_diff : cs_a;
        res_d = {res_q[62:0], cs_ge};
        acc_d = (state_q == S_SQRT) ? (acc_q << 2) : (acc_q << 1);
        cnt_d = cnt_q + 7'd1;
        if ((state_q == S_SQRT && cnt_q == 7'd63) || cnt_q == 7'd127) begin
          state_d = ret_q;
        end
      end
      S_G_LON: begin
        lonq_d = rnd_q;
        ma_d = {28'd0, ax_w};
        mb_d = {28'd0, ax_w};
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_XX;
        state_d = S_MUL;
      end
      S_G_XX: begin
        // accumulate Y^2 on top of X^2
        ma_d = {28'd0, ay_w};
        mb_d = {28'd0, ay_w};
        cnt_d = '0;
        ret_d = S_G_YY;
        state_d = S_MUL;
      end
      S_G_YY: begin
        acc_d = acc_q << 16;
        rem_d = '0;
        res_d = '0;
        cnt_d = '0;
        ret_d = S_G_DOWN;
        state_d = S_SQRT;
      end
      S_G_DOWN: begin
        down_d = res_q[43:0];
        b0q_d = B0Q;
        it_d = '0;
        conv_d = 1'b0;
        state_d = S_IT;
      end
      S_IT: begin
        cx_d = e2g_pkg::KINV_Q62;
        cy_d = '0;
        cz_d = 64'(b0q_q) <<< QSHIFT;
        cmode_d = 1'b0;
        cnt_d = '0;
        ret_d = S_G_SIN;
        state_d = S_CORD;
      end
      S_G_SIN: begin
        s_d = sin_cl;
        ma_d = sin_mag;
        mb_d = sin_mag;
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_S2;
        state_d = S_MUL;
      end
      S_G_S2: begin
        ma_d = {15'd0, e2_w};
        mb_d = acc_q[125:62];
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_W2;
        state_d = S_MUL;
      end
      S_G_W2: begin
        acc_d = {6'd0, w2_w, 58'd0};
        rem_d = '0;
        res_d = '0;
        cnt_d = '0;
        ret_d = S_G_W;
        state_d = S_SQRT;
      end
      S_G_W: begin
        ma_d = res_q;
        acc_d = {27'd0, e2g_pkg::A_MM, 4'd0, 64'd0};
        rem_d = '0;
        res_d = '0;
        cnt_d = '0;
        ret_d = S_G_N;
        state_d = S_DIV;
      end
      S_G_N: begin
        nq8_d = res_q[47:0];
        ma_d = {16'd0, res_q[47:0]};
        mb_d = {15'd0, e2_w};
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_U;
        state_d = S_MUL;
      end
      S_G_U: begin
        ma_d = acc_q[119:56];
        mb_d = as_w;
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_NE;
        state_d = S_MUL;
      end
      S_G_NE: begin
        ret_d = S_G_LAT;
        if (at_zero) begin
          cz_d = '0;
          state_d = S_G_LAT;
        end else begin
          cx_d = $signed(at_ax);
          cy_d = $signed(at_ay);
          cz_d = at_z;
          negy_d = at_neg;
          cmode_d = 1'b1;
          state_d = S_NORM;
        end
      end
      S_G_LAT: begin
        latq_d = rnd_q;
        if (s_q == '0) begin
          inval_d = 1'b1;
          height_d = '0;
          state_d = S_G_CHK;
        end else if (qhi_w >= as_w) begin
          res_d = 64'(e2g_pkg::ZS_CAP);
          state_d = S_G_Q;
        end else begin
          acc_d = {qhi_w, 64'd0};
          ma_d = as_w;
          rem_d = '0;
          res_d = '0;
          cnt_d = '0;
          ret_d = S_G_Q;
          state_d = S_DIV;
        end
      end
      S_G_Q: begin
        zs_d = (z_q[35] != s_q[63]) ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
        ma_d = {16'd0, nq8_q};
        mb_d = {8'd0, ome2_w};
        acc_d = '0;
        cnt_d = '0;
        ret_d = S_G_H;
        state_d = S_MUL;
      end
      S_G_H: begin
        if (rh_w > e2g_pkg::H_MAX) begin
          height_d = e2g_pkg::H_MAX[35:0];
        end else if (rh_w < e2g_pkg::H_MIN) begin
          height_d = e2g_pkg::H_MIN[35:0];
        end else begin
          height_d = rh_w[35:0];
        end
        inval_d = 1'b0;
        state_d = S_G_CHK;
      end
      S_G_CHK: begin
        if (latq_q == b0q_q) begin
          conv_d = 1'b1;
          state_d = S_DONE;
        end else begin
          b0q_d = latq_q;
          if (it_q == IT_W'(MAX_ITERATIONS - 1)) begin
            state_d = S_DONE;
          end else begin
            it_d = it_q + IT_W'(1);
            state_d = S_IT;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          lat_o_d = lat_sum[61:30];
          lon_o_d = lon_sum[61:30];
          hgt_o_d = height_q;
          conv_o_d = conv_q;
          inval_o_d = inval_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      cnt_q <= '0;
      it_q <= '0;
      ell_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      cnt_q <= cnt_d;
      it_q <= it_d;
      ell_q <= ell_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmode_q <= cmode_d;
    negy_q <= negy_d;
    cx_q <= cx_d;
    cy_q <= cy_d;
    cz_q <= cz_d;
    ma_q <= ma_d;
    mb_q <= mb_d;
    rem_q <= rem_d;
    res_q <= res_d;
    acc_q <= acc_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    lonq_q <= lonq_d;
    latq_q <= latq_d;
    b0q_q <= b0q_d;
    down_q <= down_d;
    s_q <= s_d;
    nq8_q <= nq8_d;
    zs_q <= zs_d;
    height_q <= height_d;
    conv_q <= conv_d;
    inval_q <= inval_d;
    lat_o_q <= lat_o_d;
    lon_o_q <= lon_o_d;
    hgt_o_q <= hgt_o_d;
    conv_o_q <= conv_o_d;
    inval_o_q <= inval_o_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign latitude_o = $signed(lat_o_q);
  assign longitude_o = $signed(lon_o_q);
  assign height_mm_o = $signed(hgt_o_q);
  assign converged_o = conv_o_q;
  assign height_invalid_o = inval_o_q;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer took an item but stayed ready");

  a_div_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < ma_q)
    else $error("division remainder not below divisor");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> it_q < IT_W'(MAX_ITERATIONS))
    else $error("pass counter beyond iteration limit");

  a_invalid_zero_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && height_invalid_o |-> height_mm_o == '0)
    else $error("invalid height beat carries non-zero height");
`endif

endmodule

`default_nettype wire
